### rtl/spf_pkg.sv
package spf_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int MAX_HALF_WIDTH = 20;
    localparam int RING_DEPTH     = 2 * MAX_HALF_WIDTH + 1;
    localparam int FILL_BITS      = $clog2(RING_DEPTH + 1);
    localparam int HW_BITS        = 5;
    localparam int PCT_BITS       = 9;
    localparam int CFG_DATA_BITS  = 9;
    localparam int CFG_IDX_BITS   = 1;
    localparam int BIT_CNT_BITS   = $clog2(SAMPLE_BITS);
    localparam int PROD_BITS      = PCT_BITS + FILL_BITS;

    localparam logic [CFG_IDX_BITS-1:0] CFG_HALF_WIDTH = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PERCENTILE = 1'd1;

    localparam logic [HW_BITS-1:0]  HALF_WIDTH_RESET = 5'd4;
    localparam logic [PCT_BITS-1:0] PERCENTILE_RESET = 9'd64;
    localparam logic [PCT_BITS-1:0] PERCENTILE_MAX   = 9'd256;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [FILL_BITS-1:0]   count_t;
    typedef logic [RING_DEPTH-1:0]  mask_t;

endpackage

### rtl/spf_in_if.sv
interface spf_in_if;
    import spf_pkg::*;

    logic    valid;
    logic    ready;
    sample_t sample_value;
    logic    last_in_record;

    modport source (output valid, output sample_value, output last_in_record, input ready);
    modport sink (input valid, input sample_value, input last_in_record, output ready);
endinterface

### rtl/spf_out_if.sv
interface spf_out_if;
    import spf_pkg::*;

    logic    valid;
    logic    ready;
    sample_t filtered_value;
    logic    last_of_run;

    modport source (output valid, output filtered_value, output last_of_run, input ready);
    modport sink (input valid, input filtered_value, input last_of_run, output ready);
endinterface

### rtl/sliding_percentile_filter_top.sv
// Sliding percentile filter for one channel of unsigned samples.
// in_ch carries one sample item with a last_in_record flag; out_ch carries
// one filtered item with a last_of_run flag. Both are valid/ready channels.
// cfg_we/cfg_index/cfg_data write half_width (index 0) and percentile_q8
// (index 1); write only while the block is idle.
// in_ch.ready is high only while no selection is running. An item that
// produces a result is followed by one setup step, 16 bit steps (each is
// one popcount over the 41 window taps, then one decision that rotates
// every tap by a bit) and one step that loads the output register.
// The last item of a record runs up to 21 such selections back to back.
// Items that produce no result leave the block idle.
// The result sits in an output register; a new item is accepted while it
// waits. When out_ch stalls, a finished selection holds until the register
// frees, and no further item is taken.
// Reset clears the fill count and control state and sets half_width to 4
// and percentile_q8 to 64. The window taps are not cleared; only samples of
// the current record are ever selected.
module sliding_percentile_filter_top (
    input  logic                               clk,
    input  logic                               rst_n,
    spf_in_if.sink                             in_ch,
    spf_out_if.source                          out_ch,
    input  logic                               cfg_we,
    input  logic [spf_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [spf_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import spf_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SETUP  = 3'd1;
    localparam logic [2:0] ST_COUNT  = 3'd2;
    localparam logic [2:0] ST_DECIDE = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0]              state_reg, state_next;
    logic [HW_BITS-1:0]      half_width_reg, half_width_next;
    logic [PCT_BITS-1:0]     percentile_reg, percentile_next;
    count_t                  fill_reg, fill_next;
    count_t                  cnt_reg, cnt_next;
    count_t                  r_reg, r_next;
    logic                    flush_reg, flush_next;
    count_t                  k_reg, k_next;
    count_t                  zeros_reg, zeros_next;
    mask_t                   mask_reg, mask_next;
    logic [BIT_CNT_BITS-1:0] bit_reg, bit_next;
    sample_t                 result_reg, result_next;
    logic                    out_valid_reg, out_valid_next;
    sample_t                 out_value_reg, out_value_next;
    logic                    out_last_reg, out_last_next;
    sample_t                 line_reg [RING_DEPTH];

    logic [HW_BITS-1:0]      w_eff;
    logic [PCT_BITS-1:0]     q_eff;
    count_t                  w_ext, full, fill_inc, cnt_in, r_in, span, m_sel;
    logic [PROD_BITS-1:0]    prod;
    logic [PROD_BITS:0]      rounded;
    count_t                  k_raw;
    mask_t                   msb_bits, mask_init;
    count_t                  zeros_sum;
    logic                    accept_in, out_free, take_one;

    assign accept_in = in_ch.valid && in_ch.ready;
    assign out_free  = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        w_eff = half_width_reg;
        if (half_width_reg == '0)
            w_eff = HW_BITS'(1);
        else if (half_width_reg > HW_BITS'(MAX_HALF_WIDTH))
            w_eff = HW_BITS'(MAX_HALF_WIDTH);
        q_eff = (percentile_reg > PERCENTILE_MAX) ? PERCENTILE_MAX : percentile_reg;
        w_ext    = FILL_BITS'(w_eff);
        full     = FILL_BITS'({w_eff, 1'b1});
        fill_inc = (fill_reg == FILL_BITS'(RING_DEPTH)) ? fill_reg : fill_reg + 1'b1;
        cnt_in   = (fill_inc < full) ? fill_inc : full;
        r_in     = ((cnt_in - 1'b1) < w_ext) ? cnt_in - 1'b1 : w_ext;
        span     = r_reg + w_ext + 1'b1;
        m_sel    = (flush_reg && span < cnt_reg) ? span : cnt_reg;
        prod     = PROD_BITS'(q_eff) * PROD_BITS'(m_sel);
        rounded  = {1'b0, prod} + (PROD_BITS + 1)'(255);
        k_raw    = FILL_BITS'(rounded >> 8);
        take_one = (flush_reg && r_reg == '0);
    end

    always_comb
    begin
        for (int i = 0; i < RING_DEPTH; i++)
        begin
            msb_bits[i]  = line_reg[i][SAMPLE_BITS-1];
            mask_init[i] = (FILL_BITS'(i) < m_sel);
        end
        zeros_sum = '0;
        for (int i = 0; i < RING_DEPTH; i++)
            zeros_sum = zeros_sum + FILL_BITS'(mask_reg[i] & ~msb_bits[i]);
    end

    always_comb
    begin
        state_next      = state_reg;
        half_width_next = half_width_reg;
        percentile_next = percentile_reg;
        fill_next       = fill_reg;
        cnt_next        = cnt_reg;
        r_next          = r_reg;
        flush_next      = flush_reg;
        k_next          = k_reg;
        zeros_next      = zeros_reg;
        mask_next       = mask_reg;
        bit_next        = bit_reg;
        result_next     = result_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_value_next  = out_value_reg;
        out_last_next   = out_last_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_HALF_WIDTH: half_width_next = cfg_data[HW_BITS-1:0];
                CFG_PERCENTILE: percentile_next = cfg_data[PCT_BITS-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept_in)
                begin
                    cnt_next = cnt_in;
                    if (in_ch.last_in_record)
                    begin
                        fill_next  = '0;
                        flush_next = 1'b1;
                        r_next     = r_in;
                        state_next = ST_SETUP;
                    end
                    else
                    begin
                        fill_next  = fill_inc;
                        flush_next = 1'b0;
                        if (cnt_in > w_ext)
                            state_next = ST_SETUP;
                    end
                end
            end
            ST_SETUP:
            begin
                k_next      = (k_raw > m_sel - 1'b1) ? m_sel - 1'b1 : k_raw;
                mask_next   = mask_init;
                bit_next    = BIT_CNT_BITS'(SAMPLE_BITS - 1);
                result_next = '0;
                state_next  = ST_COUNT;
            end
            ST_COUNT:
            begin
                zeros_next = zeros_sum;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (zeros_reg > k_reg)
                begin
                    mask_next   = mask_reg & ~msb_bits;
                    result_next = {result_reg[SAMPLE_BITS-2:0], 1'b0};
                end
                else
                begin
                    mask_next   = mask_reg & msb_bits;
                    k_next      = k_reg - zeros_reg;
                    result_next = {result_reg[SAMPLE_BITS-2:0], 1'b1};
                end
                bit_next   = bit_reg - 1'b1;
                state_next = (bit_reg == '0) ? ST_DONE : ST_COUNT;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = result_reg;
                    out_last_next  = take_one;
                    if (flush_reg && r_reg != '0)
                    begin
                        r_next     = r_reg - 1'b1;
                        state_next = ST_SETUP;
                    end
                    else
                        state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            half_width_reg <= HALF_WIDTH_RESET;
            percentile_reg <= PERCENTILE_RESET;
            fill_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            half_width_reg <= half_width_next;
            percentile_reg <= percentile_next;
            fill_reg       <= fill_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg       <= cnt_next;
        r_reg         <= r_next;
        flush_reg     <= flush_next;
        k_reg         <= k_next;
        zeros_reg     <= zeros_next;
        mask_reg      <= mask_next;
        bit_reg       <= bit_next;
        result_reg    <= result_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

    // shift in new items; rotate every tap one bit per decision
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            line_reg[0] <= in_ch.sample_value;
            for (int i = 1; i < RING_DEPTH; i++)
                line_reg[i] <= line_reg[i-1];
        end
        else if (state_reg == ST_DECIDE)
        begin
            for (int i = 0; i < RING_DEPTH; i++)
                line_reg[i] <= {line_reg[i][SAMPLE_BITS-2:0], line_reg[i][SAMPLE_BITS-1]};
        end
    end

    assign in_ch.ready           = (state_reg == ST_IDLE);
    assign out_ch.valid          = out_valid_reg;
    assign out_ch.filtered_value = out_value_reg;
    assign out_ch.last_of_run    = out_last_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_BITS'(RING_DEPTH))
        else $error("fill count beyond window depth");

    a_rank_alive: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COUNT || state_reg == ST_DECIDE)
        |-> ($countones(mask_reg) > int'(k_reg)))
        else $error("rank outside remaining candidates");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("output loaded outside a finished selection");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE) |=> (state_reg == ST_COUNT || state_reg == ST_DONE))
        else $error("bit step left the selection loop");

endmodule
